[sv/arpe_pkg.sv]
// Package: shared types and constants of the rotating ambisonic pan encoder.
package arpe_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_GAIN      = 3'd0;
   localparam csr_idx_type CSR_START     = 3'd1;
   localparam csr_idx_type CSR_STEP      = 3'd2;
   localparam csr_idx_type CSR_ELEVATION = 3'd3;
   localparam csr_idx_type CSR_PERIPH    = 3'd4;

   localparam logic [15:0] GAIN_RESET = 16'd4096;

   // Output channel slots
   localparam int NUM_CHANS = 9;
   localparam int CH_W = 0;
   localparam int CH_X = 1;
   localparam int CH_Y = 2;
   localparam int CH_Z = 3;
   localparam int CH_R = 4;
   localparam int CH_S = 5;
   localparam int CH_T = 6;
   localparam int CH_U = 7;
   localparam int CH_V = 8;

   // Sequencer steps of the shared multiplier
   typedef logic [4:0] step_type;
   localparam step_type ST_GAIN  = 5'd0;
   localparam step_type ST_XX    = 5'd1;
   localparam step_type ST_YY    = 5'd2;
   localparam step_type ST_XY    = 5'd3;
   localparam step_type ST_ZZ    = 5'd4;
   localparam step_type ST_ZX    = 5'd5;
   localparam step_type ST_YZ    = 5'd6;
   localparam step_type ST_OUT_W = 5'd7;
   localparam step_type ST_OUT_X = 5'd8;
   localparam step_type ST_OUT_Y = 5'd9;
   localparam step_type ST_OUT_Z = 5'd10;
   localparam step_type ST_OUT_R = 5'd11;
   localparam step_type ST_OUT_S = 5'd12;
   localparam step_type ST_OUT_T = 5'd13;
   localparam step_type ST_OUT_U = 5'd14;
   localparam step_type ST_OUT_V = 5'd15;
   localparam step_type ST_DRAIN = 5'd16;

   // Fixed coefficients
   localparam logic signed [17:0] W_COEF = 18'sd23170;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Controller to datapath commands
   typedef struct packed {
      logic     accept;
      logic     step_en;
      step_type step;
      logic     load_out;
   } cmd_type;

endpackage

[sv/arpe_if.sv]
// Interfaces: sample, result and configuration channels of the encoder.
interface arpe_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface arpe_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] chan_w;
   logic signed [SAMPLE_BITS-1:0] chan_x;
   logic signed [SAMPLE_BITS-1:0] chan_y;
   logic signed [SAMPLE_BITS-1:0] chan_z;
   logic signed [SAMPLE_BITS-1:0] chan_r;
   logic signed [SAMPLE_BITS-1:0] chan_s;
   logic signed [SAMPLE_BITS-1:0] chan_t;
   logic signed [SAMPLE_BITS-1:0] chan_u;
   logic signed [SAMPLE_BITS-1:0] chan_v;
   modport source (output valid, output chan_w, output chan_x, output chan_y,
                   output chan_z, output chan_r, output chan_s, output chan_t,
                   output chan_u, output chan_v, input ready);
   modport sink (input valid, input chan_w, input chan_x, input chan_y,
                 input chan_z, input chan_r, input chan_s, input chan_t,
                 input chan_u, input chan_v, output ready);
endinterface

interface arpe_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ambisonic_rotating_pan_encoder.sv]
// Top level: second-order ambisonic encoder with rotating azimuth.
//
// Usage
//  req  : one signed mono sample per beat (valid/ready).
//  rsp  : one beat per sample carrying the nine B-format channels
//         W X Y Z R S T U V, each rounded and saturated to SAMPLE_BITS.
//  csr  : register writes (index, data); always ready. Write only while
//         the block is idle. Index 1 also loads the azimuth phase.
//  From acceptance to the result register each sample takes sixteen
//  products through the single shared multiplier, a write-back drain
//  step and one load into the output register. One sample is in flight at
//  a time: a new sample is taken only once the last one has been loaded
//  into the output register. The azimuth phase advances when a sample
//  is taken. The output register keeps its result while the receiver
//  stalls; the next sample is accepted and worked on meanwhile and
//  waits in the datapath until the output register frees.
//  Reset (synchronous) restores the register defaults, zeroes the phase
//  and marks the output register empty.
module ambisonic_rotating_pan_encoder #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_BITS      = 24
) (
   input logic       clock,
   input logic       reset,
   arpe_req_if.sink  req,
   arpe_rsp_if.source rsp,
   arpe_csr_if.sink  csr
);
   import arpe_pkg::*;

   cmd_type                       cmd;
   logic signed [SAMPLE_BITS-1:0] out_chan [NUM_CHANS];

   assign csr.ready = 1'b1;

   arpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   arpe_datapath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req.sample),
      .csr_we    (csr.valid),
      .csr_index (csr.index),
      .csr_data  (csr.data),
      .out_chan  (out_chan)
   );

   assign rsp.chan_w = out_chan[CH_W];
   assign rsp.chan_x = out_chan[CH_X];
   assign rsp.chan_y = out_chan[CH_Y];
   assign rsp.chan_z = out_chan[CH_Z];
   assign rsp.chan_r = out_chan[CH_R];
   assign rsp.chan_s = out_chan[CH_S];
   assign rsp.chan_t = out_chan[CH_T];
   assign rsp.chan_u = out_chan[CH_U];
   assign rsp.chan_v = out_chan[CH_V];
endmodule

[sv/arpe_ctrl.sv]
// Controller: sequences the shared multiplier and hands results to the output register.
module arpe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpe_pkg::cmd_type cmd
);
   import arpe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = ST_GAIN;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step_en = (step_ff != ST_DRAIN);
            cmd.step    = step_ff;
            if (step_ff == ST_DRAIN) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= ST_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN && step_ff == ST_GAIN))
      else $error("accepted beat did not start the sequence");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= ST_DRAIN))
      else $error("step counter out of range");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");
endmodule

[sv/arpe_datapath.sv]
// Datapath: configuration, phase, sine ROM, shared multiplier and result registers.
module arpe_datapath #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_BITS      = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  arpe_pkg::cmd_type             cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          csr_we,
   input  arpe_pkg::csr_idx_type         csr_index,
   input  logic [31:0]                   csr_data,
   output logic signed [SAMPLE_BITS-1:0] out_chan [arpe_pkg::NUM_CHANS]
);
   import arpe_pkg::*;

   localparam int KW = $clog2(SINE_TABLE_DEPTH);
   localparam int GW = SAMPLE_BITS + 5;
   localparam int PW = GW + 18;
   localparam logic signed [PW-1:0] RND14 = PW'(16384);
   localparam logic signed [PW-1:0] RND15 = PW'(32768);
   localparam logic signed [PW-1:0] Q30   = PW'(64'd1073741824);
   localparam logic signed [PW-1:0] OUT_MAX = PW'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
   localparam logic signed [PW-1:0] OUT_MIN = -OUT_MAX - PW'(1);
   localparam longint unsigned ROM_DIV = 64'(2 * SINE_TABLE_DEPTH);

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   // Quarter-wave sine by truncated Taylor series in Q2.30
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x    = ((64'(2 * k + 1)) * HALF_PI_Q30) / ROM_DIV;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + longint'(term);
         r    = (sum + 64'sd16384) >>> 15;
         if (r > 64'sd32767) r = 64'sd32767;
         if (r < 64'sd0) r = 64'sd0;
         rom[k] = r[15:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Full-wave sine from the quarter-wave table
   function automatic logic signed [15:0] lookup(input logic [31:0] p);
      logic [30+KW:0]   scaled;
      logic [KW-1:0]    k;
      logic signed [15:0] v;
      scaled = (31+KW)'(p[29:0]) * (31+KW)'(SINE_TABLE_DEPTH);
      k      = scaled[30 +: KW];
      if (p[30]) k = KW'(SINE_TABLE_DEPTH - 1) - k;
      v = signed'(SINE_ROM[k]);
      return p[31] ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
      if (v > OUT_MAX) return OUT_MAX[SAMPLE_BITS-1:0];
      if (v < OUT_MIN) return OUT_MIN[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1:0];
   endfunction

   logic [15:0]                   gain_ff;
   logic [31:0]                   phase_ff;
   logic [31:0]                   phase_step_ff;
   logic signed [15:0]            elev_ff;
   logic                          periph_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [15:0]            x_ff, y_ff;
   logic signed [GW-1:0]          g_ff;
   logic signed [31:0]            xx_ff;
   logic signed [17:0]            cu_ff, cv_ff, cr_ff, cs_ff, ct_ff;
   logic signed [PW-1:0]          prod_ff;
   logic                          wb_en_ff;
   step_type                      wb_step_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff [NUM_CHANS];
   logic signed [SAMPLE_BITS-1:0] out_ff [NUM_CHANS];

   logic signed [GW-1:0] a_op;
   logic signed [17:0]   b_op;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] xx_ext, u_sum, v_sum, r_sum, o_sum;

   // Configuration registers and azimuth phase
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         phase_ff      <= '0;
         phase_step_ff <= '0;
         elev_ff       <= '0;
         periph_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN:      gain_ff <= csr_data[15:0];
            CSR_START:     phase_ff <= csr_data;
            CSR_STEP:      phase_step_ff <= csr_data;
            CSR_ELEVATION: elev_ff <= signed'(csr_data[15:0]);
            CSR_PERIPH:    periph_ff <= csr_data[0];
            default: ;
         endcase
      end else if (cmd.accept) begin
         phase_ff <= phase_ff + phase_step_ff;
      end
   end

   // Capture sample and read cos and sin at the current phase
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample;
         x_ff      <= lookup(phase_ff + 32'h4000_0000);
         y_ff      <= lookup(phase_ff);
      end
   end

   // Select multiplier operands per step
   always_comb begin
      a_op = GW'(x_ff);
      b_op = 18'(x_ff);
      case (cmd.step)
         ST_GAIN:  begin a_op = GW'(sample_ff); b_op = signed'({2'b00, gain_ff}); end
         ST_XX:    begin a_op = GW'(x_ff); b_op = 18'(x_ff); end
         ST_YY:    begin a_op = GW'(y_ff); b_op = 18'(y_ff); end
         ST_XY:    begin a_op = GW'(x_ff); b_op = 18'(y_ff); end
         ST_ZZ:    begin a_op = GW'(elev_ff); b_op = 18'(elev_ff); end
         ST_ZX:    begin a_op = GW'(elev_ff); b_op = 18'(x_ff); end
         ST_YZ:    begin a_op = GW'(y_ff); b_op = 18'(elev_ff); end
         ST_OUT_W: begin a_op = g_ff; b_op = W_COEF; end
         ST_OUT_X: begin a_op = g_ff; b_op = 18'(x_ff); end
         ST_OUT_Y: begin a_op = g_ff; b_op = 18'(y_ff); end
         ST_OUT_Z: begin a_op = g_ff; b_op = 18'(elev_ff); end
         ST_OUT_R: begin a_op = g_ff; b_op = cr_ff; end
         ST_OUT_S: begin a_op = g_ff; b_op = cs_ff; end
         ST_OUT_T: begin a_op = g_ff; b_op = ct_ff; end
         ST_OUT_U: begin a_op = g_ff; b_op = cu_ff; end
         ST_OUT_V: begin a_op = g_ff; b_op = cv_ff; end
         default: ;
      endcase
   end

   assign prod_in = PW'(a_op) * PW'(b_op);

   // Register the product
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_en_ff <= 1'b0;
      end else begin
         wb_en_ff <= cmd.step_en;
      end
      prod_ff    <= prod_in;
      wb_step_ff <= cmd.step;
   end

   // Round the registered product into coefficients and channels
   assign xx_ext = PW'(xx_ff);
   assign u_sum  = (xx_ext - prod_ff + RND14) >>> 15;
   assign v_sum  = ((prod_ff <<< 1) + RND14) >>> 15;
   assign r_sum  = (prod_ff + (prod_ff <<< 1) - Q30 + RND15) >>> 16;
   assign o_sum  = (prod_ff + RND14) >>> 15;

   // Write back by step
   always_ff @(posedge clock) begin
      if (wb_en_ff) begin
         case (wb_step_ff)
            ST_GAIN:  g_ff  <= GW'(prod_ff >>> 12);
            ST_XX:    xx_ff <= prod_ff[31:0];
            ST_YY:    cu_ff <= u_sum[17:0];
            ST_XY:    cv_ff <= v_sum[17:0];
            ST_ZZ:    cr_ff <= r_sum[17:0];
            ST_ZX:    cs_ff <= v_sum[17:0];
            ST_YZ:    ct_ff <= v_sum[17:0];
            ST_OUT_W: res_ff[CH_W] <= sat(o_sum);
            ST_OUT_X: res_ff[CH_X] <= sat(o_sum);
            ST_OUT_Y: res_ff[CH_Y] <= sat(o_sum);
            ST_OUT_Z: res_ff[CH_Z] <= sat(o_sum);
            ST_OUT_R: res_ff[CH_R] <= sat(o_sum);
            ST_OUT_S: res_ff[CH_S] <= sat(o_sum);
            ST_OUT_T: res_ff[CH_T] <= sat(o_sum);
            ST_OUT_U: res_ff[CH_U] <= sat(o_sum);
            ST_OUT_V: res_ff[CH_V] <= sat(o_sum);
            default: ;
         endcase
      end
   end

   // Load the output register; drop height channels when horizontal
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         for (int i = 0; i < NUM_CHANS; i++) begin
            if (!periph_ff && (i == CH_Z || i == CH_R || i == CH_S || i == CH_T)) begin
               out_ff[i] <= '0;
            end else begin
               out_ff[i] <= res_ff[i];
            end
         end
      end
   end

   assign out_chan = out_ff;
endmodule
